// ----- hw/rtl/qs_pkg.sv -----
package qs_pkg;

  localparam longint unsigned QS_MAX_QUERY_BYTES = 64'd65535;
  localparam logic [15:0] QS_LIMIT =
    (QS_MAX_QUERY_BYTES < 64'd65535) ? 16'(QS_MAX_QUERY_BYTES) : 16'hFFFF;

  localparam logic [7:0] QS_CHAR_AMP = 8'h26;  // '&'
  localparam logic [7:0] QS_CHAR_EQ  = 8'h3D;  // '='

  typedef enum logic [1:0] {
    QS_ST_OK         = 2'd0,
    QS_ST_EMPTY_NAME = 2'd1,
    QS_ST_OVERFLOW   = 2'd2
  } qs_status_t;

endpackage

// ----- hw/rtl/qs_in_if.sv -----
interface qs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_char;

  modport source(output valid, char_byte, last_char, input ready);
  modport sink(input valid, char_byte, last_char, output ready);
endinterface

// ----- hw/rtl/qs_out_if.sv -----
interface qs_out_if;
  logic                 valid;
  logic                 ready;
  logic                 pair_valid;
  logic [15:0]          name_offset;
  logic [15:0]          name_length;
  logic                 has_value;
  logic [15:0]          value_offset;
  logic [15:0]          value_length;
  logic [15:0]          pair_number;
  logic                 end_of_query;
  qs_pkg::qs_status_t   status;

  modport source(output valid, pair_valid, name_offset, name_length, has_value,
                 value_offset, value_length, pair_number, end_of_query, status,
                 input ready);
  modport sink(input valid, pair_valid, name_offset, name_length, has_value,
               value_offset, value_length, pair_number, end_of_query, status,
               output ready);
endinterface

// ----- hw/rtl/query_string_splitter.sv -----
// Path: the input register takes a byte at its transfer; the result register takes the
// result that byte causes when it is empty or out_ch.ready is high.
// Throughput: one byte per cycle unless a result waits on out_ch.ready; set by the single
// pass of compares and 16-bit counter updates between the input and result registers.
// Reset: synchronous, active low; clears the scan state, pair count and both valid flags.
module query_string_splitter (
  input  logic     clk,
  input  logic     rst_n,
  qs_in_if.sink    in_ch,
  qs_out_if.source out_ch
);
  import qs_pkg::*;

  // input register
  logic        inq_v_r;
  logic [7:0]  inq_char_r;
  logic        inq_last_r;

  // scan state
  logic        in_value_r,  in_value_nxt;
  logic [15:0] position_r,  position_nxt;
  logic [15:0] seg_start_r, seg_start_nxt;
  logic [15:0] held_len_r,  held_len_nxt;
  logic [15:0] pairs_r,     pairs_nxt;
  logic        halted_r,    halted_nxt;

  // result register
  logic        out_v_r;
  logic        res_v;
  logic        r_pair_valid,   pair_valid_r;
  logic [15:0] r_name_offset,  name_offset_r;
  logic [15:0] r_name_length,  name_length_r;
  logic        r_has_value,    has_value_r;
  logic [15:0] r_value_offset, value_offset_r;
  logic [15:0] r_value_length, value_length_r;
  logic [15:0] r_pair_number,  pair_number_r;
  logic        r_eoq,          eoq_r;
  qs_status_t  r_status,       status_r;

  logic adv;
  logic work;

  assign adv         = !out_v_r || out_ch.ready;
  assign work        = inq_v_r && adv;
  assign in_ch.ready = !inq_v_r || adv;

  always_comb begin
    logic        emitted;
    logic        restart;
    logic [15:0] pos;
    logic [15:0] seg;
    emitted = 1'b0;
    restart = 1'b0;
    pos     = position_r;
    seg     = seg_start_r;

    in_value_nxt  = in_value_r;
    position_nxt  = position_r;
    seg_start_nxt = seg_start_r;
    held_len_nxt  = held_len_r;
    pairs_nxt     = pairs_r;
    halted_nxt    = halted_r;

    res_v          = 1'b0;
    r_pair_valid   = 1'b0;
    r_name_offset  = '0;
    r_name_length  = '0;
    r_has_value    = 1'b0;
    r_value_offset = '0;
    r_value_length = '0;
    r_pair_number  = pairs_r;
    r_eoq          = 1'b0;
    r_status       = QS_ST_OK;

    if (halted_r) begin
      restart = inq_last_r;
    end else if (pos >= QS_LIMIT) begin
      res_v      = 1'b1;
      r_eoq      = 1'b1;
      r_status   = QS_ST_OVERFLOW;
      restart    = inq_last_r;
      halted_nxt = !inq_last_r;
    end else if (!in_value_r && inq_char_r == QS_CHAR_EQ && pos == seg) begin
      res_v      = 1'b1;
      r_eoq      = 1'b1;
      r_status   = QS_ST_EMPTY_NAME;
      restart    = inq_last_r;
      halted_nxt = !inq_last_r;
    end else begin
      if (!in_value_r) begin
        if (inq_char_r == QS_CHAR_AMP) begin
          // skip an empty segment
          if (pos != seg) begin
            pairs_nxt     = pairs_r + 16'd1;
            emitted       = 1'b1;
            r_pair_valid  = 1'b1;
            r_name_offset = seg;
            r_name_length = pos - seg;
          end
          seg_start_nxt = pos + 16'd1;
        end else if (inq_char_r == QS_CHAR_EQ) begin
          held_len_nxt  = pos - seg;
          in_value_nxt  = 1'b1;
          seg_start_nxt = pos + 16'd1;
        end
      end else if (inq_char_r == QS_CHAR_AMP) begin
        pairs_nxt      = pairs_r + 16'd1;
        emitted        = 1'b1;
        r_pair_valid   = 1'b1;
        r_name_offset  = seg - 16'd1 - held_len_r;
        r_name_length  = held_len_r;
        r_has_value    = 1'b1;
        r_value_offset = seg;
        r_value_length = pos - seg;
        in_value_nxt   = 1'b0;
        seg_start_nxt  = pos + 16'd1;
      end

      res_v = emitted;
      if (inq_last_r) begin
        res_v   = 1'b1;
        r_eoq   = 1'b1;
        restart = 1'b1;
        if (!emitted && in_value_nxt) begin
          // close a value still open at the end of the query
          pairs_nxt      = pairs_nxt + 16'd1;
          r_pair_valid   = 1'b1;
          r_name_offset  = seg_start_nxt - 16'd1 - held_len_nxt;
          r_name_length  = held_len_nxt;
          r_has_value    = 1'b1;
          r_value_offset = seg_start_nxt;
          r_value_length = pos + 16'd1 - seg_start_nxt;
        end
      end else begin
        position_nxt = pos + 16'd1;
      end
      r_pair_number = pairs_nxt;
    end

    if (restart) begin
      in_value_nxt  = 1'b0;
      position_nxt  = '0;
      seg_start_nxt = '0;
      held_len_nxt  = '0;
      pairs_nxt     = '0;
      halted_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r     <= 1'b0;
      out_v_r     <= 1'b0;
      in_value_r  <= 1'b0;
      position_r  <= '0;
      seg_start_r <= '0;
      held_len_r  <= '0;
      pairs_r     <= '0;
      halted_r    <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        inq_v_r <= 1'b1;
      end else if (adv) begin
        inq_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= work && res_v;
      end
      if (work) begin
        in_value_r  <= in_value_nxt;
        position_r  <= position_nxt;
        seg_start_r <= seg_start_nxt;
        held_len_r  <= held_len_nxt;
        pairs_r     <= pairs_nxt;
        halted_r    <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      inq_char_r <= in_ch.char_byte;
      inq_last_r <= in_ch.last_char;
    end
    // load the result register only when a result is produced
    if (work && res_v) begin
      pair_valid_r   <= r_pair_valid;
      name_offset_r  <= r_name_offset;
      name_length_r  <= r_name_length;
      has_value_r    <= r_has_value;
      value_offset_r <= r_value_offset;
      value_length_r <= r_value_length;
      pair_number_r  <= r_pair_number;
      eoq_r          <= r_eoq;
      status_r       <= r_status;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.pair_valid   = pair_valid_r;
  assign out_ch.name_offset  = name_offset_r;
  assign out_ch.name_length  = name_length_r;
  assign out_ch.has_value    = has_value_r;
  assign out_ch.value_offset = value_offset_r;
  assign out_ch.value_length = value_length_r;
  assign out_ch.pair_number  = pair_number_r;
  assign out_ch.end_of_query = eoq_r;
  assign out_ch.status       = status_r;

endmodule

// ----- tb/query_string_splitter_tb.sv -----
`timescale 1ns / 1ps

module query_string_splitter_tb;
  import qs_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_BYTES = 650;

  typedef enum int {SHAPE_WELL, SHAPE_NOISE, SHAPE_BROKEN} query_shape_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BLOCKS} stall_mode_t;

  typedef struct packed {
    logic        pair_valid;
    logic [15:0] name_offset;
    logic [15:0] name_length;
    logic        has_value;
    logic [15:0] value_offset;
    logic [15:0] value_length;
    logic [15:0] pair_number;
    logic        end_of_query;
    qs_status_t  status;
  } pair_rec_t;

  class pair_ledger;
    logic        in_value;
    logic [15:0] position;
    logic [15:0] seg_start;
    logic [15:0] held_len;
    logic [15:0] pair_count;
    logic        halted;
    pair_rec_t   expected_pairs[$];
    int          failures;
    int          live_bytes;

    function new();
      restart();
      failures   = 0;
      live_bytes = 0;
    endfunction

    function void restart();
      in_value   = 1'b0;
      position   = '0;
      seg_start  = '0;
      held_len   = '0;
      pair_count = '0;
      halted     = 1'b0;
    endfunction

    function pair_rec_t blank(qs_status_t st);
      pair_rec_t r;
      r = '0;
      r.pair_number  = pair_count;
      r.end_of_query = 1'b1;
      r.status       = st;
      return r;
    endfunction

    function pair_rec_t pair_with_value(logic [15:0] val_start, logic [15:0] val_len,
                                        logic eoq);
      pair_rec_t r;
      r = '0;
      r.pair_valid   = 1'b1;
      r.name_offset  = val_start - 16'd1 - held_len;
      r.name_length  = held_len;
      r.has_value    = 1'b1;
      r.value_offset = val_start;
      r.value_length = val_len;
      r.pair_number  = pair_count;
      r.end_of_query = eoq;
      r.status       = QS_ST_OK;
      return r;
    endfunction

    // Advance the scan by one accepted byte and queue what it should produce.
    function void note_byte(logic [7:0] c, logic lst);
      pair_rec_t   r;
      logic [15:0] pos;
      logic        made;
      pos  = position;
      made = 1'b0;
      r    = '0;
      if (halted) begin
        if (lst) restart();
        return;
      end
      live_bytes++;
      if (pos >= QS_LIMIT) begin
        expected_pairs.push_back(blank(QS_ST_OVERFLOW));
        if (lst) restart();
        else halted = 1'b1;
        return;
      end
      if (!in_value) begin
        if (c == QS_CHAR_AMP) begin
          if (pos != seg_start) begin
            pair_count++;
            r.pair_valid  = 1'b1;
            r.name_offset = seg_start;
            r.name_length = pos - seg_start;
            r.pair_number = pair_count;
            made = 1'b1;
          end
          seg_start = pos + 16'd1;
        end else if (c == QS_CHAR_EQ) begin
          if (pos == seg_start) begin
            expected_pairs.push_back(blank(QS_ST_EMPTY_NAME));
            if (lst) restart();
            else halted = 1'b1;
            return;
          end
          held_len  = pos - seg_start;
          in_value  = 1'b1;
          seg_start = pos + 16'd1;
        end
      end else if (c == QS_CHAR_AMP) begin
        pair_count++;
        r         = pair_with_value(seg_start, pos - seg_start, 1'b0);
        made      = 1'b1;
        in_value  = 1'b0;
        seg_start = pos + 16'd1;
      end
      if (lst) begin
        if (made) begin
          r.end_of_query = 1'b1;
        end else if (in_value) begin
          // open value runs to the end of the query
          pair_count++;
          r = pair_with_value(seg_start, pos + 16'd1 - seg_start, 1'b1);
        end else begin
          r = blank(QS_ST_OK);
        end
        expected_pairs.push_back(r);
        restart();
        return;
      end
      position = pos + 16'd1;
      if (made) expected_pairs.push_back(r);
    endfunction

    function void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_pair(pair_rec_t got);
      pair_rec_t want;
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pair_number %0h",
                 $time, got.pair_number);
        failures++;
        return;
      end
      want = expected_pairs.pop_front();
      check_field("pair_valid",   16'(want.pair_valid),   16'(got.pair_valid));
      check_field("name_offset",  want.name_offset,       got.name_offset);
      check_field("name_length",  want.name_length,       got.name_length);
      check_field("has_value",    16'(want.has_value),    16'(got.has_value));
      check_field("value_offset", want.value_offset,      got.value_offset);
      check_field("value_length", want.value_length,      got.value_length);
      check_field("pair_number",  want.pair_number,       got.pair_number);
      check_field("end_of_query", 16'(want.end_of_query), 16'(got.end_of_query));
      check_field("status",       16'(want.status),       16'(got.status));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  qs_in_if  in_ch();
  qs_out_if out_ch();

  query_string_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pair_ledger ledger = new();
  logic [7:0] query_bytes[$];
  int         burst_left = 0;
  int         idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      ledger.note_byte(in_ch.char_byte, in_ch.last_char);
  end

  always @(posedge clk) begin
    pair_rec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.pair_valid   = out_ch.pair_valid;
      got.name_offset  = out_ch.name_offset;
      got.name_length  = out_ch.name_length;
      got.has_value    = out_ch.has_value;
      got.value_offset = out_ch.value_offset;
      got.value_length = out_ch.value_length;
      got.pair_number  = out_ch.pair_number;
      got.end_of_query = out_ch.end_of_query;
      got.status       = out_ch.status;
      ledger.check_pair(got);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver backpressure: switch between stall patterns every so often.
  initial begin
    stall_mode_t mode;
    int span;
    int period;
    out_ch.ready <= 1'b0;
    forever begin
      mode   = stall_mode_t'($urandom_range(0, 3));
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 7);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:     out_ch.ready <= 1'b1;
          RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ch.ready <= (k % period) != 0;
          default:     out_ch.ready <= (k % 16) < 10;
        endcase
      end
    end
  end

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == QS_CHAR_AMP || b == QS_CHAR_EQ);
    return b;
  endfunction

  function automatic void push_plain(int count);
    repeat (count) query_bytes.push_back(plain_char());
  endfunction

  function automatic void push_value(int count);
    repeat (count) begin
      if ($urandom_range(0, 5) == 0) query_bytes.push_back(QS_CHAR_EQ);
      else query_bytes.push_back(plain_char());
    end
  endfunction

  function automatic void load_text(string s);
    query_bytes.delete();
    for (int i = 0; i < s.len(); i++) query_bytes.push_back(s[i]);
  endfunction

  function automatic void build_query(query_shape_t shape);
    int n;
    query_bytes.delete();
    if (shape == SHAPE_NOISE) begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1, 2: query_bytes.push_back(QS_CHAR_AMP);
          3, 4:    query_bytes.push_back(QS_CHAR_EQ);
          default: query_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    if ($urandom_range(0, 7) == 0) query_bytes.push_back(QS_CHAR_AMP);
    n = $urandom_range(1, 3);
    for (int p = 0; p < n; p++) begin
      push_plain($urandom_range(1, 4));
      if ($urandom_range(0, 3) != 0) begin
        query_bytes.push_back(QS_CHAR_EQ);
        push_value($urandom_range(0, 4));
      end
      if (p < n - 1 || $urandom_range(0, 1) == 1) begin
        query_bytes.push_back(QS_CHAR_AMP);
        if ($urandom_range(0, 7) == 0) query_bytes.push_back(QS_CHAR_AMP);
      end
    end
    if (shape == SHAPE_BROKEN) begin
      // empty name right after a separator
      query_bytes.push_back(QS_CHAR_AMP);
      query_bytes.push_back(QS_CHAR_EQ);
      repeat ($urandom_range(0, 4)) query_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(32, 96);
      end else begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= b;
    in_ch.last_char <= lst;
    do @(posedge clk);
    while (in_ch.ready !== 1'b1);
    burst_left--;
  endtask

  task automatic send_query();
    for (int i = 0; i < query_bytes.size(); i++)
      send_byte(query_bytes[i], i == query_bytes.size() - 1);
  endtask

  initial begin
    int start_bytes;
    int pick;
    in_ch.valid     <= 1'b0;
    in_ch.char_byte <= 8'h00;
    in_ch.last_char <= 1'b0;
    rst_n           <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    load_text("=");          send_query();
    load_text("&");          send_query();
    load_text("ab");         send_query();
    load_text("a=");         send_query();
    load_text("k=v=w&&x&");  send_query();
    load_text("q=&=zz");     send_query();
    query_bytes = {8'hFF, QS_CHAR_EQ, 8'h00};
    send_query();

    start_bytes = ledger.live_bytes;
    while (ledger.live_bytes - start_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) build_query(SHAPE_WELL);
      else if (pick < 9) build_query(SHAPE_NOISE);
      else build_query(SHAPE_BROKEN);
      send_query();
    end

    build_query(SHAPE_WELL);
    send_query();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/qs_pkg.sv
hw/rtl/qs_in_if.sv
hw/rtl/qs_out_if.sv
hw/rtl/query_string_splitter.sv
tb/query_string_splitter_tb.sv
